### hdl/poq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poq_pkg: shared types for the preemptible overlay queue
// Event kinds, status codes, queue entry layout and result beat layout.
// ----------------------------------------------------------------------------
package poq_pkg;

    // Event kinds carried by an input beat
    typedef enum logic [2:0] {
        KIND_ENQUEUE  = 3'd0,
        KIND_PLAY_NOW = 3'd1,
        KIND_ADVANCE  = 3'd2,
        KIND_STOP_IF  = 3'd3,
        KIND_RESET    = 3'd4
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_DEFERRED = 2'd2
    } status_t;

    // One job record as held in the queue
    typedef struct packed {
        logic        cancelable;
        logic [31:0] duration;
        logic [7:0]  id;
    } entry_t;

    // Queue control from the scheduler
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } fifo_ctl_t;

    // One result beat
    typedef struct packed {
        status_t     status;
        logic        stop_valid;
        logic [7:0]  stop_id;
        logic        start_valid;
        logic [7:0]  start_id;
        logic [31:0] start_duration;
        logic        frame_request;
        logic        is_active;
        logic [7:0]  current_id;
        logic        current_cancelable;
        logic [3:0]  queued_count;
    } res_t;

endpackage

### hdl/poq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poq_if: valid/ready channels of the preemptible overlay queue
// Event channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface poq_job_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  job_id;
    logic [31:0] job_duration;
    logic        job_cancelable;
    logic        current_done;
    logic        cancel_request;

    modport source (
        output valid, kind, job_id, job_duration, job_cancelable,
               current_done, cancel_request,
        input  ready
    );
    modport sink (
        input  valid, kind, job_id, job_duration, job_cancelable,
               current_done, cancel_request,
        output ready
    );
endinterface

interface poq_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        stop_valid;
    logic [7:0]  stop_id;
    logic        start_valid;
    logic [7:0]  start_id;
    logic [31:0] start_duration;
    logic        frame_request;
    logic        is_active;
    logic [7:0]  current_id;
    logic        current_cancelable;
    logic [3:0]  queued_count;

    modport source (
        output valid, status, stop_valid, stop_id, start_valid, start_id,
               start_duration, frame_request, is_active, current_id,
               current_cancelable, queued_count,
        input  ready
    );
    modport sink (
        input  valid, status, stop_valid, stop_id, start_valid, start_id,
               start_duration, frame_request, is_active, current_id,
               current_cancelable, queued_count,
        output ready
    );
endinterface

### hdl/preemptible_overlay_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptible_overlay_queue: overlay job scheduler
// Job queue plus one current slot; one result beat per event beat.
// ----------------------------------------------------------------------------
// Takes one event beat per clock while the result sink keeps up and returns
// exactly one result beat for it, in the cycle after acceptance, from the
// output register. Throughput is one event per cycle under the same
// condition: the whole event is decided combinationally by flag tests and one
// queue push or pop, and the head of the queue is kept read ahead from the
// queue memory so a pop need not wait for a memory read. job.ready is low
// only while a finished result waits in the output register and the sink does
// not take it. A reset event drains the queue in that same cycle; no clearing
// pass is needed after power-on reset. queued_count is the fill count modulo 16.
// ----------------------------------------------------------------------------
module preemptible_overlay_queue #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    poq_job_if.sink    job,
    poq_res_if.source  res
);
    import poq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Current slot
    logic [7:0]        cur_id_reg, cur_id_next;
    logic              cur_cancel_reg, cur_cancel_next;
    logic              active_reg, active_next;

    // Output register
    res_t              res_reg, res_next;
    logic              out_valid_reg;

    // Queue
    fifo_ctl_t         fifo_ctl;
    entry_t            fifo_wdata;
    entry_t            fifo_head;
    logic [CNT_W-1:0]  fifo_count;
    logic [CNT_W-1:0]  fifo_count_next;
    logic              fifo_full;
    logic [CNT_W+3:0]  count_ext;

    logic              fire;
    logic              adv_go;

    assign job.ready = !out_valid_reg || res.ready;
    assign fire      = job.valid && job.ready;

    assign fifo_wdata.id         = job.job_id;
    assign fifo_wdata.duration   = job.job_duration;
    assign fifo_wdata.cancelable = job.job_cancelable;

    poq_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (fifo_ctl),
        .wdata      (fifo_wdata),
        .head       (fifo_head),
        .count      (fifo_count),
        .count_next (fifo_count_next),
        .full       (fifo_full)
    );

    assign adv_go = (active_reg && (job.current_done ||
                                    (cur_cancel_reg && job.cancel_request))) ||
                    (!active_reg && (fifo_count != '0));

    assign count_ext = {4'd0, fifo_count_next};

    // Event decode
    always_comb
    begin
        fifo_ctl        = '0;
        cur_id_next     = cur_id_reg;
        cur_cancel_next = cur_cancel_reg;
        active_next     = active_reg;
        res_next        = '0;
        res_next.status = STATUS_OK;

        unique case (kind_t'(job.kind))
            KIND_ENQUEUE:
            begin
                if (!fifo_full)
                begin
                    fifo_ctl.push          = fire;
                    res_next.frame_request = 1'b1;
                end
                else
                begin
                    res_next.status = STATUS_FULL;
                end
            end
            KIND_PLAY_NOW:
            begin
                if (!active_reg || cur_cancel_reg)
                begin
                    // preempt the current slot
                    if (cur_id_reg != 8'd0)
                    begin
                        res_next.stop_valid = 1'b1;
                        res_next.stop_id    = cur_id_reg;
                    end
                    cur_id_next     = job.job_id;
                    cur_cancel_next = job.job_cancelable;
                    active_next     = 1'b1;
                    if (job.job_id != 8'd0)
                    begin
                        res_next.start_valid    = 1'b1;
                        res_next.start_id       = job.job_id;
                        res_next.start_duration = job.job_duration;
                    end
                    res_next.frame_request = 1'b1;
                end
                else if (!fifo_full)
                begin
                    fifo_ctl.push          = fire;
                    res_next.status        = STATUS_DEFERRED;
                    res_next.frame_request = 1'b1;
                end
                else
                begin
                    res_next.status = STATUS_FULL;
                end
            end
            KIND_ADVANCE:
            begin
                if (adv_go)
                begin
                    if (cur_id_reg != 8'd0)
                    begin
                        res_next.stop_valid = 1'b1;
                        res_next.stop_id    = cur_id_reg;
                    end
                    if (fifo_count != '0)
                    begin
                        fifo_ctl.pop    = fire;
                        cur_id_next     = fifo_head.id;
                        cur_cancel_next = fifo_head.cancelable;
                        active_next     = 1'b1;
                        if (fifo_head.id != 8'd0)
                        begin
                            res_next.start_valid    = 1'b1;
                            res_next.start_id       = fifo_head.id;
                            res_next.start_duration = fifo_head.duration;
                        end
                    end
                    else
                    begin
                        cur_id_next     = 8'd0;
                        cur_cancel_next = 1'b0;
                        active_next     = 1'b0;
                    end
                    res_next.frame_request = 1'b1;
                end
            end
            KIND_STOP_IF:
            begin
                if (active_reg && (job.job_id != 8'd0) && (cur_id_reg == job.job_id))
                begin
                    res_next.stop_valid    = 1'b1;
                    res_next.stop_id       = job.job_id;
                    res_next.frame_request = 1'b1;
                end
            end
            KIND_RESET:
            begin
                fifo_ctl.clear  = fire;
                cur_id_next     = 8'd0;
                cur_cancel_next = 1'b0;
                active_next     = 1'b0;
            end
            default:
            begin
                // unknown kinds leave state alone and report snapshots
            end
        endcase

        res_next.is_active          = active_next;
        res_next.current_id         = cur_id_next;
        res_next.current_cancelable = cur_cancel_next;
        res_next.queued_count       = count_ext[3:0];
    end

    // Slot state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_id_reg     <= 8'd0;
            cur_cancel_reg <= 1'b0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                cur_id_reg     <= cur_id_next;
                cur_cancel_reg <= cur_cancel_next;
                active_reg     <= active_next;
                out_valid_reg  <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid              = out_valid_reg;
    assign res.status             = res_reg.status;
    assign res.stop_valid         = res_reg.stop_valid;
    assign res.stop_id            = res_reg.stop_id;
    assign res.start_valid        = res_reg.start_valid;
    assign res.start_id           = res_reg.start_id;
    assign res.start_duration     = res_reg.start_duration;
    assign res.frame_request      = res_reg.frame_request;
    assign res.is_active          = res_reg.is_active;
    assign res.current_id         = res_reg.current_id;
    assign res.current_cancelable = res_reg.current_cancelable;
    assign res.queued_count       = res_reg.queued_count;

endmodule

### hdl/poq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poq_fifo: job record queue
// Circular buffer with registered read. The head entry is read ahead at the
// next read pointer every cycle, with a bypass for a write into that slot,
// so the head is ready in the cycle after any push, pop or clear.
// ----------------------------------------------------------------------------
module poq_fifo #(
    parameter int QUEUE_DEPTH = 8,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  poq_pkg::fifo_ctl_t  ctl,
    input  poq_pkg::entry_t     wdata,
    output poq_pkg::entry_t     head,
    output logic [CNT_W-1:0]    count,
    output logic [CNT_W-1:0]    count_next,
    output logic                full
);
    import poq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    entry_t             mem [QUEUE_DEPTH];
    entry_t             head_mem_reg;
    entry_t             bypass_data_reg;
    logic               bypass_reg;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]   count_reg;

    // Pointer and fill count updates
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (ctl.clear)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            count_next  = '0;
        end
        else if (ctl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            count_next  = count_reg + CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_next  = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            // write into the slot being read ahead: the memory returns old data, so the write data is taken instead
            bypass_reg <= ctl.push && (wr_ptr_reg == rd_ptr_next);
        end
    end

    // Storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
        head_mem_reg    <= mem[rd_ptr_next];
        bypass_data_reg <= wdata;
    end

    assign head  = bypass_reg ? bypass_data_reg : head_mem_reg;
    assign count = count_reg;
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));

endmodule

### hdl/poq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poq_checker: port-level checks for the preemptible overlay queue
// Watches the event and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module poq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        job_valid,
    input logic        job_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  status,
    input logic        stop_valid,
    input logic        start_valid,
    input logic [7:0]  start_id,
    input logic [31:0] start_duration,
    input logic        frame_request,
    input logic        is_active,
    input logic [7:0]  current_id
);
    import poq_pkg::*;

    // an accepted event always yields a result beat next cycle
    a_event_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready |=> res_valid)
        else $error("accepted event produced no result beat");

    // a stalled result beat stays presented
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat withdrawn while stalled");

    // a started job is the one now in the slot
    a_start_matches_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && start_valid |-> is_active && (current_id == start_id))
        else $error("start command does not match current slot");

    // no start command means zeroed start fields
    a_idle_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !start_valid |-> (start_id == 8'd0) && (start_duration == 32'd0))
        else $error("start fields not cleared without start command");

    // a dropped record causes nothing else
    a_full_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == STATUS_FULL) |-> !frame_request && !start_valid && !stop_valid)
        else $error("dropped record issued commands");

endmodule

bind preemptible_overlay_queue poq_checker u_poq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (job.valid),
    .job_ready      (job.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .status         (res.status),
    .stop_valid     (res.stop_valid),
    .start_valid    (res.start_valid),
    .start_id       (res.start_id),
    .start_duration (res.start_duration),
    .frame_request  (res.frame_request),
    .is_active      (res.is_active),
    .current_id     (res.current_id)
);

### test/preemptible_overlay_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptible_overlay_queue_tb: self-checking bench for the overlay scheduler
// Sends event beats (directed corner cases, then weighted random episodes),
// predicts each result beat from a scheduler model kept in the bench and
// compares every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module preemptible_overlay_queue_tb;
    import poq_pkg::*;

    localparam int QUEUE_DEPTH  = 8;
    localparam int RAND_EVENTS  = 1150;
    localparam int PHASE_BEATS  = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_MAX   = 10;

    // kinds the block ignores
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    // episode flavors of the random part
    localparam int EPI_FILL  = 0;
    localparam int EPI_DRAIN = 1;
    localparam int EPI_MIXED = 2;

    // one event beat as the bench holds it
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  id;
        logic [31:0] dur;
        logic        canc;
        logic        done;
        logic        cancel;
    } event_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // driven values, known from time zero
    logic   drv_valid  = 1'b0;
    event_t drv_ev     = '0;
    logic   take_ready = 1'b0;

    poq_job_if job_ch ();
    poq_res_if res_ch ();

    assign job_ch.valid          = drv_valid;
    assign job_ch.kind           = drv_ev.kind;
    assign job_ch.job_id         = drv_ev.id;
    assign job_ch.job_duration   = drv_ev.dur;
    assign job_ch.job_cancelable = drv_ev.canc;
    assign job_ch.current_done   = drv_ev.done;
    assign job_ch.cancel_request = drv_ev.cancel;
    assign res_ch.ready          = take_ready;

    preemptible_overlay_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (job_ch.sink),
        .res   (res_ch.source)
    );

    event_t pending_evs[$];
    res_t   expected_res[$];
    int     beats_in    = 0;
    int     fault_count = 0;

    // scheduler state mirrored by the bench
    entry_t job_fifo[QUEUE_DEPTH];
    int     fifo_rd  = 0;
    int     fifo_wr  = 0;
    int     fifo_cnt = 0;
    entry_t cur_job  = '0;
    logic   cur_busy = 1'b0;

    // push a record unless the queue is full
    function automatic logic fifo_put(event_t ev);
        if (fifo_cnt >= QUEUE_DEPTH)
            return 1'b0;
        job_fifo[fifo_wr] = '{cancelable: ev.canc, duration: ev.dur, id: ev.id};
        fifo_wr = (fifo_wr + 1) % QUEUE_DEPTH;
        fifo_cnt++;
        return 1'b1;
    endfunction

    // apply one event to the mirrored state and return the result beat
    function automatic res_t schedule_event(event_t ev);
        res_t r;
        logic go;
        r = '0;
        r.status = STATUS_OK;
        case (ev.kind)
            KIND_ENQUEUE:
            begin
                if (fifo_put(ev))
                    r.frame_request = 1'b1;
                else
                    r.status = STATUS_FULL;
            end
            KIND_PLAY_NOW:
            begin
                if (!cur_busy || cur_job.cancelable)
                begin
                    if (cur_job.id != 8'd0)
                    begin
                        r.stop_valid = 1'b1;
                        r.stop_id    = cur_job.id;
                    end
                    cur_job  = '{cancelable: ev.canc, duration: ev.dur, id: ev.id};
                    cur_busy = 1'b1;
                    if (ev.id != 8'd0)
                    begin
                        r.start_valid    = 1'b1;
                        r.start_id       = ev.id;
                        r.start_duration = ev.dur;
                    end
                    r.frame_request = 1'b1;
                end
                else if (fifo_put(ev))
                begin
                    r.status        = STATUS_DEFERRED;
                    r.frame_request = 1'b1;
                end
                else
                begin
                    r.status = STATUS_FULL;
                end
            end
            KIND_ADVANCE:
            begin
                go = (cur_busy && (ev.done || (cur_job.cancelable && ev.cancel))) ||
                     (!cur_busy && fifo_cnt > 0);
                if (go)
                begin
                    if (cur_job.id != 8'd0)
                    begin
                        r.stop_valid = 1'b1;
                        r.stop_id    = cur_job.id;
                    end
                    if (fifo_cnt > 0)
                    begin
                        cur_job  = job_fifo[fifo_rd];
                        fifo_rd  = (fifo_rd + 1) % QUEUE_DEPTH;
                        fifo_cnt--;
                        cur_busy = 1'b1;
                        if (cur_job.id != 8'd0)
                        begin
                            r.start_valid    = 1'b1;
                            r.start_id       = cur_job.id;
                            r.start_duration = cur_job.duration;
                        end
                    end
                    else
                    begin
                        cur_job  = '0;
                        cur_busy = 1'b0;
                    end
                    r.frame_request = 1'b1;
                end
            end
            KIND_STOP_IF:
            begin
                if (cur_busy && ev.id != 8'd0 && cur_job.id == ev.id)
                begin
                    r.stop_valid    = 1'b1;
                    r.stop_id       = ev.id;
                    r.frame_request = 1'b1;
                end
            end
            KIND_RESET:
            begin
                fifo_rd  = 0;
                fifo_wr  = 0;
                fifo_cnt = 0;
                cur_job  = '0;
                cur_busy = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.is_active          = cur_busy;
        r.current_id         = cur_job.id;
        r.current_cancelable = cur_job.cancelable;
        r.queued_count       = 4'(fifo_cnt);
        return r;
    endfunction

    function automatic string res_text(res_t r);
        return $sformatf("st=%0d stop=%0b/%0d start=%0b/%0d/%08h fr=%0b act=%0b cur=%0d/%0b n=%0d",
                         r.status, r.stop_valid, r.stop_id, r.start_valid, r.start_id,
                         r.start_duration, r.frame_request, r.is_active, r.current_id,
                         r.current_cancelable, r.queued_count);
    endfunction

    task automatic add_event(logic [2:0] kind, logic [7:0] id, logic [31:0] dur,
                             logic canc, logic done, logic cancel);
        pending_evs.push_back('{kind: kind, id: id, dur: dur, canc: canc,
                                done: done, cancel: cancel});
    endtask

    // random event; the episode flavor weights the kinds
    function automatic event_t random_event(int flavor);
        event_t ev;
        int     roll;
        int     w_enq;
        int     w_play;
        int     w_adv;
        int     w_stop;
        case (flavor)
            EPI_FILL:  begin w_enq = 55; w_play = 25; w_adv = 10; w_stop = 5;  end
            EPI_DRAIN: begin w_enq = 10; w_play = 10; w_adv = 60; w_stop = 15; end
            default:   begin w_enq = 25; w_play = 25; w_adv = 30; w_stop = 15; end
        endcase
        roll = $urandom_range(99);
        if (roll < w_enq)
            ev.kind = KIND_ENQUEUE;
        else if (roll < w_enq + w_play)
            ev.kind = KIND_PLAY_NOW;
        else if (roll < w_enq + w_play + w_adv)
            ev.kind = KIND_ADVANCE;
        else if (roll < w_enq + w_play + w_adv + w_stop)
            ev.kind = KIND_STOP_IF;
        else
            ev.kind = 3'($urandom_range(KIND_RESET, KIND_SPARE_LAST));
        // small id pool so stop targets hit the current job often
        ev.id = ($urandom_range(3) != 0) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
        roll = $urandom_range(7);
        ev.dur    = (roll == 0) ? 32'd0 : (roll == 1) ? 32'hFFFF_FFFF : 32'($urandom);
        ev.canc   = 1'($urandom_range(1));
        ev.done   = 1'($urandom_range(1));
        ev.cancel = 1'($urandom_range(1));
        return ev;
    endfunction

    // clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // event driver
    always @(posedge clk or negedge rst_n)
    begin
        int pct;
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_ev    <= '0;
        end
        else
        begin
            if (drv_valid && job_ch.ready)
            begin
                expected_res.push_back(schedule_event(drv_ev));
                beats_in++;
            end
            if (!drv_valid || job_ch.ready)
            begin
                pct = (beats_in < PHASE_BEATS) ? 10 : (beats_in < 2 * PHASE_BEATS) ? 72 : 0;
                if (pending_evs.size() != 0 && $urandom_range(99) >= pct)
                begin
                    drv_ev    <= pending_evs.pop_front();
                    drv_valid <= 1'b1;
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        int   pct;
        if (!rst_n)
        begin
            take_ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got = {res_ch.status, res_ch.stop_valid, res_ch.stop_id, res_ch.start_valid,
                       res_ch.start_id, res_ch.start_duration, res_ch.frame_request,
                       res_ch.is_active, res_ch.current_id, res_ch.current_cancelable,
                       res_ch.queued_count};
                if (expected_res.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("%0t unexpected result beat: %s", $realtime, res_text(got));
                end
                else
                begin
                    want = expected_res.pop_front();
                    if (got !== want)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                        begin
                            $display("%0t result mismatch", $realtime);
                            $display("    expected %s", res_text(want));
                            $display("    actual   %s", res_text(got));
                        end
                    end
                end
            end
            pct = (beats_in < PHASE_BEATS) ? 72 : (beats_in < 2 * PHASE_BEATS) ? 10 : 0;
            take_ready <= ($urandom_range(99) >= pct);
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int flavor;
        int len;
        int n;

        // idle queue, then a deferred play and its pop
        add_event(KIND_ADVANCE,  8'd0,   32'd0,         1'b0, 1'b1, 1'b1);
        add_event(KIND_STOP_IF,  8'd0,   32'd0,         1'b0, 1'b0, 1'b0);
        add_event(KIND_PLAY_NOW, 8'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        add_event(KIND_PLAY_NOW, 8'd5,   32'd100,       1'b0, 1'b0, 1'b0);
        add_event(KIND_STOP_IF,  8'd0,   32'd0,         1'b0, 1'b0, 1'b0);
        add_event(KIND_ADVANCE,  8'd0,   32'd0,         1'b0, 1'b0, 1'b1);
        add_event(KIND_ADVANCE,  8'd0,   32'd0,         1'b0, 1'b1, 1'b0);
        add_event(KIND_STOP_IF,  8'd5,   32'd0,         1'b0, 1'b0, 1'b0);
        // fill the queue, then overflow on enqueue and on deferred play
        add_event(KIND_ENQUEUE,  8'd255, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        add_event(KIND_ENQUEUE,  8'd0,   32'd0,         1'b1, 1'b0, 1'b0);
        add_event(KIND_ENQUEUE,  8'd128, 32'd1,         1'b0, 1'b0, 1'b0);
        add_event(KIND_ENQUEUE,  8'd1,   32'h8000_0000, 1'b1, 1'b0, 1'b0);
        add_event(KIND_ENQUEUE,  8'd2,   32'h5555_5555, 1'b0, 1'b0, 1'b0);
        add_event(KIND_ENQUEUE,  8'd3,   32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0);
        add_event(KIND_ENQUEUE,  8'd4,   32'd7,         1'b0, 1'b0, 1'b0);
        add_event(KIND_ENQUEUE,  8'd6,   32'd8,         1'b1, 1'b0, 1'b0);
        add_event(KIND_ENQUEUE,  8'd9,   32'd9,         1'b0, 1'b0, 1'b0);
        add_event(KIND_PLAY_NOW, 8'd10,  32'd10,        1'b1, 1'b0, 1'b0);
        // finish, force cancel, then preempt a cancelable job
        add_event(KIND_ADVANCE,  8'd0,   32'd0,         1'b0, 1'b1, 1'b0);
        add_event(KIND_ADVANCE,  8'd0,   32'd0,         1'b0, 1'b0, 1'b1);
        add_event(KIND_PLAY_NOW, 8'd200, 32'd20,        1'b1, 1'b0, 1'b0);
        add_event(KIND_PLAY_NOW, 8'd201, 32'd21,        1'b0, 1'b0, 1'b0);
        // ignored kinds, drain, then a job that ends with an empty queue
        add_event(KIND_SPARE_FIRST, 8'd201, 32'd0,      1'b1, 1'b1, 1'b1);
        add_event(KIND_SPARE_LAST,  8'd201, 32'd0,      1'b1, 1'b1, 1'b1);
        add_event(KIND_RESET,    8'd0,   32'd0,         1'b0, 1'b0, 1'b0);
        add_event(KIND_ADVANCE,  8'd0,   32'd0,         1'b0, 1'b1, 1'b1);
        add_event(KIND_PLAY_NOW, 8'd3,   32'd30,        1'b1, 1'b0, 1'b0);
        add_event(KIND_ADVANCE,  8'd0,   32'd0,         1'b0, 1'b1, 1'b0);

        // random episodes: fill bursts, drain runs and mixed traffic
        n = 0;
        while (n < RAND_EVENTS)
        begin
            flavor = $urandom_range(EPI_MIXED);
            len    = $urandom_range(4, 20);
            repeat (len)
            begin
                pending_evs.push_back(random_event(flavor));
                n++;
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_evs.size() != 0 || drv_valid || expected_res.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fault_count == 0)
            $display("preemptible_overlay_queue_tb: done, clean");
        else
            $display("preemptible_overlay_queue_tb: done, errors");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("preemptible_overlay_queue_tb: done, errors");
        $finish;
    end

endmodule
